// ===== sv/sit_pkg.sv =====
package sit_pkg;

    // Table geometry
    localparam int TABLE_DEPTH = 64;
    localparam int ADDR_W      = 32;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = IDX_W + 1;
    localparam int WORD_W      = 2 * ADDR_W;

    // Operation codes
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_ERASE  = 2'd1;
    localparam logic [1:0] OP_INIT   = 2'd2;

    // Write data selects
    localparam logic [1:0] WSEL_KEY   = 2'd0;
    localparam logic [1:0] WSEL_RDATA = 2'd1;
    localparam logic [1:0] WSEL_ZERO  = 2'd2;
    localparam logic [1:0] WSEL_MEMSZ = 2'd3;

    // Commands from controller to datapath
    typedef struct packed {
        logic             cap_in;
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        logic [1:0]       wr_sel;
    } sit_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic key_lt;
        logic entry_match;
    } sit_stat_t;

endpackage

// ===== sv/sit_ram.sv =====
module sit_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/sit_datapath.sv =====
module sit_datapath (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    input  logic [sit_pkg::ADDR_W-1:0]   cfg_data,
    input  logic [sit_pkg::ADDR_W-1:0]   in_start,
    input  logic [sit_pkg::ADDR_W-1:0]   in_size,
    input  sit_pkg::sit_cmd_t            cmd,
    output sit_pkg::sit_stat_t           stat
);

    logic [sit_pkg::ADDR_W-1:0] mem_size_reg;
    logic [sit_pkg::ADDR_W-1:0] key_start_reg;
    logic [sit_pkg::ADDR_W-1:0] key_size_reg;
    logic [sit_pkg::WORD_W-1:0] wr_data;
    logic [sit_pkg::WORD_W-1:0] rd_data;

    // Hold the memory size register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mem_size_reg <= '0;
        end
        else if (cfg_valid)
        begin
            mem_size_reg <= cfg_data;
        end
    end

    // Capture the key of the accepted transaction
    always_ff @(posedge clk)
    begin
        if (cmd.cap_in)
        begin
            key_start_reg <= in_start;
            key_size_reg  <= in_size;
        end
    end

    // Select write data: start in the low half, size in the high half
    always_comb
    begin
        case (cmd.wr_sel)
            sit_pkg::WSEL_KEY:   wr_data = {key_size_reg, key_start_reg};
            sit_pkg::WSEL_RDATA: wr_data = rd_data;
            sit_pkg::WSEL_ZERO:  wr_data = '0;
            sit_pkg::WSEL_MEMSZ: wr_data = {{sit_pkg::ADDR_W{1'b0}}, mem_size_reg};
            default:             wr_data = '0;
        endcase
    end

    sit_ram #(
        .WIDTH (sit_pkg::WORD_W),
        .DEPTH (sit_pkg::TABLE_DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (cmd.wr_en),
        .wr_addr (cmd.wr_addr),
        .wr_data (wr_data),
        .rd_en   (cmd.rd_en),
        .rd_addr (cmd.rd_addr),
        .rd_data (rd_data)
    );

    // Compare the key against the entry just read
    assign stat.key_lt      = key_start_reg < rd_data[sit_pkg::ADDR_W-1:0];
    assign stat.entry_match = rd_data == {key_size_reg, key_start_reg};

endmodule

// ===== sv/sit_ctrl.sv =====
module sit_ctrl (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [1:0]                 in_op,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic                       out_status,
    output logic [sit_pkg::IDX_W-1:0]  out_position,
    output logic [sit_pkg::CNT_W-1:0]  out_removed,
    output logic [sit_pkg::CNT_W-1:0]  out_count,
    output sit_pkg::sit_cmd_t          cmd,
    input  sit_pkg::sit_stat_t         stat
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_SRCH_RD  = 4'd1;
    localparam logic [3:0] S_SRCH_CMP = 4'd2;
    localparam logic [3:0] S_SHIFT    = 4'd3;
    localparam logic [3:0] S_INS_WR   = 4'd4;
    localparam logic [3:0] S_ERASE    = 4'd5;
    localparam logic [3:0] S_INIT0    = 4'd6;
    localparam logic [3:0] S_INIT1    = 4'd7;
    localparam logic [3:0] S_DONE     = 4'd8;

    localparam logic [sit_pkg::CNT_W-1:0] FULL_COUNT = sit_pkg::CNT_W'(sit_pkg::TABLE_DEPTH);

    logic [3:0]                state_reg,     state_next;
    logic                      status_reg,    status_next;
    logic [sit_pkg::CNT_W-1:0] count_reg,     count_next;
    logic [sit_pkg::IDX_W-1:0] lo_reg,        lo_next;
    logic [sit_pkg::IDX_W-1:0] hi_reg,        hi_next;
    logic [sit_pkg::IDX_W-1:0] mid_reg,       mid_next;
    logic [sit_pkg::CNT_W-1:0] r_reg,         r_next;
    logic [sit_pkg::CNT_W-1:0] w_reg,         w_next;
    logic                      pend_reg,      pend_next;
    logic [sit_pkg::IDX_W-1:0] pend_addr_reg, pend_addr_next;
    logic [sit_pkg::CNT_W-1:0] removed_reg,   removed_next;
    logic                      out_valid_reg, out_valid_next;
    logic                      out_status_reg;
    logic [sit_pkg::IDX_W-1:0] out_pos_reg;
    logic [sit_pkg::CNT_W-1:0] out_removed_reg;
    logic [sit_pkg::CNT_W-1:0] out_count_reg;
    logic                      accept;
    logic                      load_out;
    logic                      do_rd;
    logic [sit_pkg::CNT_W-1:0] r_dec;

    function automatic logic [sit_pkg::IDX_W-1:0] r_dec_of_count(
        input logic [sit_pkg::CNT_W-1:0] c
    );
        logic [sit_pkg::CNT_W-1:0] d;
        d = c - 1'b1;
        return d[sit_pkg::IDX_W-1:0];
    endfunction

    assign in_ready = state_reg == S_IDLE;
    assign accept   = in_valid && in_ready;
    assign load_out = (state_reg == S_DONE) && (!out_valid_reg || out_ready);
    assign r_dec    = r_reg - 1'b1;

    // Sequence search, shift, compaction and init
    always_comb
    begin
        state_next     = state_reg;
        status_next    = status_reg;
        count_next     = count_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        r_next         = r_reg;
        w_next         = w_reg;
        pend_next      = pend_reg;
        pend_addr_next = pend_addr_reg;
        removed_next   = removed_reg;
        do_rd          = 1'b0;
        cmd            = '0;
        cmd.wr_sel     = sit_pkg::WSEL_RDATA;

        case (state_reg)
            S_IDLE:
            begin
                cmd.cap_in = accept;
                if (accept)
                begin
                    status_next  = 1'b0;
                    lo_next      = '0;
                    removed_next = '0;
                    r_next       = '0;
                    w_next       = '0;
                    pend_next    = 1'b0;
                    case (in_op)
                        sit_pkg::OP_INSERT:
                        begin
                            if (count_reg == FULL_COUNT)
                            begin
                                status_next = 1'b1;
                                state_next  = S_DONE;
                            end
                            else
                            begin
                                hi_next    = (count_reg == '0) ? '0
                                             : r_dec_of_count(count_reg);
                                state_next = S_SRCH_RD;
                            end
                        end
                        sit_pkg::OP_ERASE: state_next = S_ERASE;
                        sit_pkg::OP_INIT:  state_next = S_INIT0;
                        default:           state_next = S_DONE;
                    endcase
                end
            end

            S_SRCH_RD:
            begin
                if (lo_reg < hi_reg)
                begin
                    mid_next    = lo_reg + ((hi_reg - lo_reg) >> 1);
                    cmd.rd_en   = 1'b1;
                    cmd.rd_addr = mid_next;
                    state_next  = S_SRCH_CMP;
                end
                else
                begin
                    r_next     = count_reg;
                    pend_next  = 1'b0;
                    state_next = S_SHIFT;
                end
            end

            S_SRCH_CMP:
            begin
                if (stat.key_lt)
                begin
                    hi_next = mid_reg;
                end
                else
                begin
                    lo_next = mid_reg + 1'b1;
                end
                state_next = S_SRCH_RD;
            end

            // Move entries up one place, reading from the top down
            S_SHIFT:
            begin
                do_rd          = r_reg > {1'b0, lo_reg};
                cmd.rd_en      = do_rd;
                cmd.rd_addr    = r_dec[sit_pkg::IDX_W-1:0];
                cmd.wr_en      = pend_reg;
                cmd.wr_addr    = pend_addr_reg;
                cmd.wr_sel     = sit_pkg::WSEL_RDATA;
                pend_next      = do_rd;
                pend_addr_next = r_reg[sit_pkg::IDX_W-1:0];
                if (do_rd)
                begin
                    r_next = r_dec;
                end
                else
                begin
                    state_next = S_INS_WR;
                end
            end

            S_INS_WR:
            begin
                cmd.wr_en   = 1'b1;
                cmd.wr_addr = lo_reg;
                cmd.wr_sel  = sit_pkg::WSEL_KEY;
                count_next  = count_reg + 1'b1;
                state_next  = S_DONE;
            end

            // Read every entry, write back the ones that do not match
            S_ERASE:
            begin
                do_rd       = r_reg < count_reg;
                cmd.rd_en   = do_rd;
                cmd.rd_addr = r_reg[sit_pkg::IDX_W-1:0];
                cmd.wr_addr = w_reg[sit_pkg::IDX_W-1:0];
                cmd.wr_sel  = sit_pkg::WSEL_RDATA;
                pend_next   = do_rd;
                if (do_rd)
                begin
                    r_next = r_reg + 1'b1;
                end
                if (pend_reg)
                begin
                    if (stat.entry_match)
                    begin
                        removed_next = removed_reg + 1'b1;
                    end
                    else
                    begin
                        cmd.wr_en = 1'b1;
                        w_next    = w_reg + 1'b1;
                    end
                end
                if (!do_rd && !pend_reg)
                begin
                    count_next = w_reg;
                    state_next = S_DONE;
                end
            end

            S_INIT0:
            begin
                cmd.wr_en   = 1'b1;
                cmd.wr_addr = '0;
                cmd.wr_sel  = sit_pkg::WSEL_ZERO;
                state_next  = S_INIT1;
            end

            S_INIT1:
            begin
                cmd.wr_en   = 1'b1;
                cmd.wr_addr = sit_pkg::IDX_W'(1);
                cmd.wr_sel  = sit_pkg::WSEL_MEMSZ;
                count_next  = sit_pkg::CNT_W'(2);
                state_next  = S_DONE;
            end

            S_DONE:
            begin
                if (load_out)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold a result until the downstream side takes it
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg    <= status_next;
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        mid_reg       <= mid_next;
        r_reg         <= r_next;
        w_reg         <= w_next;
        pend_addr_reg <= pend_addr_next;
        removed_reg   <= removed_next;
    end

    // Load the result register
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_status_reg  <= status_reg;
            out_pos_reg     <= lo_reg;
            out_removed_reg <= removed_reg;
            out_count_reg   <= count_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_status   = out_status_reg;
    assign out_position = out_pos_reg;
    assign out_removed  = out_removed_reg;
    assign out_count    = out_count_reg;

endmodule

// ===== sv/sorted_interval_table.sv =====
// Channel   Direction  Handshake                      Payload
// s_axis    in         s_axis_tvalid / s_axis_tready  tuser: operation; tdata: start, size
// m_axis    out        m_axis_tvalid / m_axis_tready  tuser: status; tdata: position, removed,
//                                                     entry count
// cfg       in         cfg_valid / cfg_ready          cfg_data: memory size
//
// One operation at a time; the table sits in one RAM with one write and one registered read
// port. Init writes the two sentinel entries; an unknown operation or an insert into a full
// table goes straight to the result. Insert bisects for the position, shifts the entries
// above it up one place and writes the key; erase reads every entry once. Reset clears the
// entry count, memory size and controller state; table contents are undefined until written
// and need no clearing pass. A finished result waits in the output register while the next
// operation is accepted; a stalled output holds the controller in its final state.
module sorted_interval_table (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [63:0]                s_axis_tdata,   // [31:0] entry_start, [63:32] entry_size
    input  logic [1:0]                 s_axis_tuser,   // [1:0] operation
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [23:0]                m_axis_tdata,   // [5:0] insert_position,
                                                       // [12:6] removed_count,
                                                       // [19:13] entry_count, [23:20] zero
    output logic                       m_axis_tuser,   // [0] status
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [sit_pkg::ADDR_W-1:0] cfg_data
);

    sit_pkg::sit_cmd_t         cmd;
    sit_pkg::sit_stat_t        stat;
    logic [sit_pkg::IDX_W-1:0] out_position;
    logic [sit_pkg::CNT_W-1:0] out_removed;
    logic [sit_pkg::CNT_W-1:0] out_count;

    assign cfg_ready = 1'b1;

    sit_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_axis_tvalid),
        .in_ready     (s_axis_tready),
        .in_op        (s_axis_tuser),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_status   (m_axis_tuser),
        .out_position (out_position),
        .out_removed  (out_removed),
        .out_count    (out_count),
        .cmd          (cmd),
        .stat         (stat)
    );

    sit_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .in_start  (s_axis_tdata[31:0]),
        .in_size   (s_axis_tdata[63:32]),
        .cmd       (cmd),
        .stat      (stat)
    );

    // Pack the result fields
    assign m_axis_tdata = {4'b0000, out_count, out_removed, out_position};

endmodule

// ===== sv/sit_checker.sv =====
module sit_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic        m_axis_tuser
);

    // A pending result stays offered until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // One operation at a time: no accept right after an accept
    a_one_op: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted while busy");

    // Entry count never exceeds the table depth
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[19:13] <= 7'd64)
        else $error("entry count beyond table depth");

    // A dropped insert reports a full table and no position or removals
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |->
            m_axis_tdata[19:13] == 7'd64 && m_axis_tdata[12:0] == 13'd0)
        else $error("full status with inconsistent fields");

endmodule

bind sorted_interval_table sit_checker u_sit_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

    // Operation code that the table ignores
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam int RANDOM_ITEMS = 1050;
    localparam int QUIET_TAIL   = 80;
    localparam int DRAIN_CYCLES = 200;
    localparam int RUN_LIMIT    = 1000000;

    typedef struct {
        logic                       is_cfg;
        logic [1:0]                 op;
        logic [sit_pkg::ADDR_W-1:0] start_addr;
        logic [sit_pkg::ADDR_W-1:0] len;
        logic [sit_pkg::ADDR_W-1:0] mem_value;
        int                         gap;
    } table_request_t;

    typedef struct packed {
        logic       full;
        logic [5:0] position;
        logic [6:0] removed;
        logic [6:0] count;
    } table_result_t;

    typedef struct {
        logic [sit_pkg::ADDR_W-1:0] start_addr;
        logic [sit_pkg::ADDR_W-1:0] len;
    } range_t;

    logic                       clk           = 1'b0;
    logic                       rst_n         = 1'b0;
    logic                       s_axis_tvalid = 1'b0;
    logic                       s_axis_tready;
    logic [63:0]                s_axis_tdata  = '0;   // [31:0] entry_start, [63:32] entry_size
    logic [1:0]                 s_axis_tuser  = '0;   // [1:0] operation
    logic                       m_axis_tvalid;
    logic                       m_axis_tready = 1'b0;
    logic [23:0]                m_axis_tdata;         // [5:0] insert_position,
                                                      // [12:6] removed_count,
                                                      // [19:13] entry_count, [23:20] zero
    logic                       m_axis_tuser;         // [0] status
    logic                       cfg_valid     = 1'b0;
    logic                       cfg_ready;
    logic [sit_pkg::ADDR_W-1:0] cfg_data      = '0;

    table_request_t pending_ops[$];
    table_result_t  expected_results[$];
    int             error_count = 0;
    int             cycle_count = 0;
    int             gap_left    = 0;
    int             stall_left  = 0;
    logic           stall_mood  = 1'b1;

    // Predicted table contents and memory size
    logic [sit_pkg::ADDR_W-1:0] model_starts [sit_pkg::TABLE_DEPTH];
    logic [sit_pkg::ADDR_W-1:0] model_sizes  [sit_pkg::TABLE_DEPTH];
    int unsigned                model_count    = 0;
    logic [sit_pkg::ADDR_W-1:0] model_mem_size = '0;

    // Stimulus planning: multiset of ranges believed to be in the table
    range_t                     planned_ranges[$];
    logic [sit_pkg::ADDR_W-1:0] planned_mem_size = '0;
    logic [sit_pkg::ADDR_W-1:0] start_pool[6];
    logic                       idle_on = 1'b1;

    sorted_interval_table i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Apply one operation to the predicted table and return its result
    function automatic table_result_t apply_table_op(logic [1:0] op,
                                                     logic [sit_pkg::ADDR_W-1:0] key,
                                                     logic [sit_pkg::ADDR_W-1:0] len);
        table_result_t res;
        int unsigned   lo;
        int unsigned   hi;
        int unsigned   mid;
        int unsigned   i;
        int unsigned   w;
        int unsigned   hits;
        res  = '0;
        hits = 0;
        case (op)
            sit_pkg::OP_INIT:
            begin
                model_starts[0] = '0;
                model_sizes[0]  = '0;
                model_starts[1] = model_mem_size;
                model_sizes[1]  = '0;
                model_count     = 2;
            end
            sit_pkg::OP_INSERT:
            begin
                if (model_count >= sit_pkg::TABLE_DEPTH)
                begin
                    res.full = 1'b1;
                end
                else
                begin
                    // bisect over all but the last entry
                    lo = 0;
                    if (model_count != 0)
                    begin
                        hi = model_count - 1;
                        while (lo < hi)
                        begin
                            mid = lo + (hi - lo) / 2;
                            if (key < model_starts[mid])
                                hi = mid;
                            else
                                lo = mid + 1;
                        end
                    end
                    for (i = model_count; i > lo; i--)
                    begin
                        model_starts[i] = model_starts[i-1];
                        model_sizes[i]  = model_sizes[i-1];
                    end
                    model_starts[lo] = key;
                    model_sizes[lo]  = len;
                    model_count++;
                    res.position = lo[5:0];
                end
            end
            sit_pkg::OP_ERASE:
            begin
                // drop every exact match and compact the rest in order
                w = 0;
                for (i = 0; i < model_count; i++)
                begin
                    if (model_starts[i] == key && model_sizes[i] == len)
                    begin
                        hits++;
                    end
                    else
                    begin
                        model_starts[w] = model_starts[i];
                        model_sizes[w]  = model_sizes[i];
                        w++;
                    end
                end
                model_count = w;
                res.removed = hits[6:0];
            end
            default:
            begin
            end
        endcase
        res.count = model_count[6:0];
        return res;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            error_count++;
        end
    endfunction

    // Track what the table should hold so erase targets can hit real entries
    function automatic void plan_effect(logic [1:0] op, logic [sit_pkg::ADDR_W-1:0] key,
                                        logic [sit_pkg::ADDR_W-1:0] len);
        range_t r;
        int     i;
        r.start_addr = key;
        r.len        = len;
        case (op)
            sit_pkg::OP_INIT:
            begin
                planned_ranges.delete();
                r.start_addr = '0;
                r.len        = '0;
                planned_ranges.insert(planned_ranges.size(), r);
                r.start_addr = planned_mem_size;
                planned_ranges.insert(planned_ranges.size(), r);
            end
            sit_pkg::OP_INSERT:
            begin
                if (planned_ranges.size() < sit_pkg::TABLE_DEPTH)
                    planned_ranges.insert(planned_ranges.size(), r);
            end
            sit_pkg::OP_ERASE:
            begin
                for (i = planned_ranges.size() - 1; i >= 0; i--)
                begin
                    if (planned_ranges[i].start_addr == key && planned_ranges[i].len == len)
                        planned_ranges.delete(i);
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic int draw_gap();
        if (idle_on && $urandom_range(0, 2) == 0)
            return $urandom_range(1, 6);
        return 0;
    endfunction

    function automatic void add_op(logic [1:0] op, logic [sit_pkg::ADDR_W-1:0] key,
                                   logic [sit_pkg::ADDR_W-1:0] len);
        table_request_t req;
        req.is_cfg     = 1'b0;
        req.op         = op;
        req.start_addr = key;
        req.len        = len;
        req.mem_value  = '0;
        req.gap        = draw_gap();
        pending_ops.insert(pending_ops.size(), req);
        plan_effect(op, key, len);
    endfunction

    function automatic void add_cfg(logic [sit_pkg::ADDR_W-1:0] value);
        table_request_t req;
        req.is_cfg     = 1'b1;
        req.op         = sit_pkg::OP_INIT;
        req.start_addr = '0;
        req.len        = '0;
        req.mem_value  = value;
        req.gap        = draw_gap();
        pending_ops.insert(pending_ops.size(), req);
        planned_mem_size = value;
    endfunction

    function automatic logic [sit_pkg::ADDR_W-1:0] pick_start();
        if ($urandom_range(0, 9) < 7)
            return start_pool[$urandom_range(0, 5)];
        return $urandom();
    endfunction

    function automatic logic [sit_pkg::ADDR_W-1:0] pick_size();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return 32'd1;
            2:       return '1;
            3:       return {28'd0, start_pool[5][3:0]};
            default: return $urandom();
        endcase
    endfunction

    function automatic void plan_directed();
        // before any init: empty table, single entry, ignored code, erase
        add_op(sit_pkg::OP_INSERT, 32'd10, 32'd3);
        add_op(sit_pkg::OP_INSERT, 32'd5, 32'd1);
        add_op(OP_UNUSED, 32'd7, 32'd7);
        add_op(sit_pkg::OP_ERASE, 32'd10, 32'd3);
        // sentinels at zero memory size, then erase all three equal ranges
        add_op(sit_pkg::OP_INIT, '0, '0);
        add_op(sit_pkg::OP_INSERT, '0, '0);
        add_op(sit_pkg::OP_ERASE, '0, '0);
        // full-range memory and extreme fields
        add_cfg('1);
        add_op(sit_pkg::OP_INIT, '0, '0);
        add_op(sit_pkg::OP_INSERT, '1, '1);
        add_op(sit_pkg::OP_INSERT, 32'h8000_0000, 32'h7fff_ffff);
        add_op(sit_pkg::OP_INSERT, '0, '1);
        add_op(sit_pkg::OP_INSERT, 32'h7fff_ffff, '0);
        add_op(sit_pkg::OP_ERASE, '1, '0);
        add_op(sit_pkg::OP_INSERT, '1, 32'd1);
        add_op(sit_pkg::OP_ERASE, 32'd1, 32'd1);
        add_op(OP_UNUSED, 32'haaaa_aaaa, 32'h5555_5555);
        add_op(sit_pkg::OP_ERASE, '0, '0);
        // starts above memory size leave the table unsorted
        add_cfg(32'h100);
        add_op(sit_pkg::OP_INIT, '0, '0);
        add_op(sit_pkg::OP_INSERT, 32'h200, 32'h10);
        add_op(sit_pkg::OP_INSERT, 32'h150, 32'h5555_5555);
        add_op(sit_pkg::OP_INSERT, 32'h300, '0);
        add_op(sit_pkg::OP_INSERT, 32'h80, 32'haaaa_aaaa);
    endfunction

    function automatic void plan_random();
        int                         issued;
        int                         phase_len;
        int                         n;
        int                         roll;
        logic                       fill;
        logic [sit_pkg::ADDR_W-1:0] mem;
        range_t                     r;
        issued = 0;
        while (issued < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 4))
                0:       mem = '0;
                1:       mem = '1;
                2:       mem = $urandom_range(0, 4096);
                3:       mem = 32'h8000_0000;
                default: mem = $urandom();
            endcase
            idle_on       = ($urandom_range(0, 3) != 0);
            start_pool[0] = '0;
            start_pool[1] = '1;
            start_pool[2] = mem;
            start_pool[3] = $urandom();
            start_pool[4] = $urandom_range(0, 64);
            start_pool[5] = $urandom();
            add_cfg(mem);
            add_op(sit_pkg::OP_INIT, '0, '0);
            issued++;
            fill      = ($urandom_range(0, 1) == 0);
            phase_len = $urandom_range(40, 130);
            for (n = 0; n < phase_len && issued < RANDOM_ITEMS; n++)
            begin
                roll = $urandom_range(0, 99);
                if (fill && n < 70)
                    roll = 0;
                if (roll < 50)
                begin
                    add_op(sit_pkg::OP_INSERT, pick_start(), pick_size());
                end
                else if (roll < 90)
                begin
                    // mostly erase a range that is present, sometimes a stray one
                    if (planned_ranges.size() != 0 && $urandom_range(0, 3) != 0)
                    begin
                        r = planned_ranges[$urandom_range(0, planned_ranges.size() - 1)];
                        add_op(sit_pkg::OP_ERASE, r.start_addr, r.len);
                    end
                    else
                    begin
                        add_op(sit_pkg::OP_ERASE, pick_start(), pick_size());
                    end
                end
                else if (roll < 94)
                begin
                    add_op(sit_pkg::OP_INIT, $urandom(), $urandom());
                end
                else
                begin
                    add_op(OP_UNUSED, $urandom(), $urandom());
                end
                issued++;
            end
        end
    endfunction

    // Drive requests and memory size writes from the pending queue
    always @(posedge clk or negedge rst_n)
    begin : drive_requests
        table_request_t head;
        logic           op_taken;
        logic           cfg_taken;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= '0;
            cfg_valid     <= 1'b0;
            cfg_data      <= '0;
            gap_left      <= 0;
        end
        else
        begin
            op_taken  = s_axis_tvalid && s_axis_tready;
            cfg_taken = cfg_valid && cfg_ready;
            if ((s_axis_tvalid && !op_taken) || (cfg_valid && !cfg_taken))
            begin
                // hold the offered transaction until it is taken
            end
            else if (gap_left != 0)
            begin
                s_axis_tvalid <= 1'b0;
                cfg_valid     <= 1'b0;
                gap_left      <= gap_left - 1;
            end
            else if (pending_ops.size() == 0)
            begin
                s_axis_tvalid <= 1'b0;
                cfg_valid     <= 1'b0;
            end
            else if (pending_ops[0].is_cfg)
            begin
                // write memory size only with nothing outstanding
                s_axis_tvalid <= 1'b0;
                if (!op_taken && expected_results.size() == 0)
                begin
                    head = pending_ops.pop_front();
                    cfg_valid <= 1'b1;
                    cfg_data  <= head.mem_value;
                    gap_left  <= head.gap;
                end
                else
                begin
                    cfg_valid <= 1'b0;
                end
            end
            else
            begin
                head = pending_ops.pop_front();
                cfg_valid     <= 1'b0;
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {head.len, head.start_addr};
                s_axis_tuser  <= head.op;
                gap_left      <= head.gap;
            end
        end
    end

    // Stall the result channel in random bursts; no stalls near the end
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            stall_left    <= 0;
        end
        else if (stall_left != 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left    <= stall_left - 1;
        end
        else if (stall_mood && pending_ops.size() >= QUIET_TAIL && $urandom_range(0, 5) == 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left    <= $urandom_range(0, 5);
        end
        else
        begin
            m_axis_tready <= 1'b1;
        end
    end

    // Change the stall pattern now and then so some stretches run clean
    always @(posedge clk)
    begin
        if (cycle_count % 256 == 0)
            stall_mood <= ($urandom_range(0, 3) != 0);
    end

    // Check each result transaction, then predict accepted requests
    always @(posedge clk)
    begin : check_results
        table_result_t want;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: result with none expected, expected nothing actual %h/%b",
                             $time, m_axis_tdata, m_axis_tuser);
                    error_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("status", 32'(want.full), 32'(m_axis_tuser));
                    check_field("insert_position", 32'(want.position),
                                32'(m_axis_tdata[5:0]));
                    check_field("removed_count", 32'(want.removed),
                                32'(m_axis_tdata[12:6]));
                    check_field("entry_count", 32'(want.count), 32'(m_axis_tdata[19:13]));
                    check_field("tdata padding", '0, 32'(m_axis_tdata[23:20]));
                end
            end
            if (cfg_valid && cfg_ready)
                model_mem_size = cfg_data;
            if (s_axis_tvalid && s_axis_tready)
                expected_results.insert(expected_results.size(),
                                        apply_table_op(s_axis_tuser, s_axis_tdata[31:0],
                                                       s_axis_tdata[63:32]));
        end
    end

    // Bound the run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT)
        begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    initial
    begin : run_sequence
        int i;
        plan_directed();
        plan_random();
        // run the tail without source gaps
        for (i = pending_ops.size() - QUIET_TAIL; i < pending_ops.size(); i++)
            pending_ops[i].gap = 0;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        do
            @(negedge clk);
        while (pending_ops.size() != 0 || s_axis_tvalid || cfg_valid ||
               expected_results.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (error_count == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
